>>> rtl/virtual_cpu_interrupt_interface_top_macros.svh
`ifndef VIRTUAL_CPU_INTERRUPT_INTERFACE_TOP_MACROS_SVH
`define VIRTUAL_CPU_INTERRUPT_INTERFACE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VCPUII_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vcpuii assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VCPUII_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vcpuii assertion failed");

`endif

>>> rtl/vcpuii_pkg.sv
package vcpuii_pkg;

  localparam logic [1:0] ST_INVALID  = 2'd0;
  localparam logic [1:0] ST_PENDING  = 2'd1;
  localparam logic [1:0] ST_ACTIVE   = 2'd2;
  localparam logic [1:0] ST_RESERVED = 2'd3;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_LOAD  = 2'd3;

  localparam logic [7:0] OFF_CTLR = 8'h00;
  localparam logic [7:0] OFF_PMR  = 8'h04;
  localparam logic [7:0] OFF_IAR  = 8'h0C;
  localparam logic [7:0] OFF_EOIR = 8'h10;

  localparam logic [9:0] SPURIOUS_ID = 10'd1023;

  typedef struct packed {
    logic [1:0] st;
    logic [9:0] vid;
    logic [9:0] pid;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FWD  = 6'b000010,
    S_SCAN = 6'b000100,
    S_IAR  = 6'b001000,
    S_EOIR = 6'b010000,
    S_DONE = 6'b100000
  } fsm_t;

endpackage

>>> rtl/virtual_cpu_interrupt_interface_top.sv
// Virtual CPU interrupt interface over a bank of list registers.
// Input channel (in_valid/in_ready) carries one beat per item: a tick, a bus
// read, a bus write or a list register load. Output channel
// (out_valid/out_ready) returns exactly one result beat per item.
// The list registers live in one synchronous RAM read one entry per cycle;
// a valid bit per entry, cleared at reset and on EOI, marks empty entries.
// An item goes from IDLE straight to DONE for CTLR, PMR, loads, errors, an IAR
// read with nothing forwarded and ticks with the interface or group 0
// disabled; an IAR read of a forwarded entry passes through IAR. A tick that
// has a forwarded entry checks it in FWD and keeps it if still pending, else
// scans in SCAN from the entry after the pointer; an EOIR write scans in EOIR
// from entry 0, reading one entry per cycle through the RAM port. One item
// is worked on at a time.
// A new beat is accepted while a finished result still waits in the output
// register; a stalled receiver only stops the block once the next result is
// ready to leave. Reset (rst, synchronous) invalidates all entries, clears
// the pointer and group and interface enables, and releases irq_n. The user
// writes the interface enable via cfg_wr_en/cfg_wr_data only while idle; not enforced.
module virtual_cpu_interrupt_interface_top #(
  parameter int NUM_LIST_REGS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  offset,
  input  logic [31:0] write_data,
  input  logic [5:0]  lr_index,
  input  logic [1:0]  lr_state_in,
  input  logic [9:0]  lr_vid,
  input  logic [9:0]  lr_pid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        virq_n,
  output logic        eoi_valid,
  output logic [9:0]  eoi_pid,
  output logic        access_error
);

  `include "virtual_cpu_interrupt_interface_top_macros.svh"

  localparam int IDXW = $clog2(NUM_LIST_REGS);
  localparam int CW   = $clog2(NUM_LIST_REGS + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_LIST_REGS - 1);

  vcpuii_pkg::entry_t mem [NUM_LIST_REGS];
  vcpuii_pkg::entry_t rd_q;
  logic                rd_vld;
  logic [NUM_LIST_REGS-1:0] vld;

  vcpuii_pkg::fsm_t state, state_next;
  logic [IDXW-1:0] fwd_ptr, fwd_ptr_next;
  logic [IDXW-1:0] chk_addr, chk_addr_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic            forwarding, forwarding_next;
  logic            grp0, grp0_next;
  logic            grp1, grp1_next;
  logic            irq_n, irq_n_next;
  logic            virt_en;
  logic [9:0]      eoir_vid, eoir_vid_next;
  logic [31:0]     w_rdata, w_rdata_next;
  logic            w_eoi_v, w_eoi_v_next;
  logic [9:0]      w_eoi_pid, w_eoi_pid_next;
  logic            w_err, w_err_next;
  logic            out_valid_next;

  logic               mem_we, mem_re, vld_set, vld_clr;
  logic [IDXW-1:0]    mem_waddr, rd_addr;
  vcpuii_pkg::entry_t mem_wdata;
  logic [IDXW-1:0]    ptr_inc, chk_inc;
  logic [1:0]         eff_st;
  logic               in_acc, out_load;

  assign in_ready = (state == vcpuii_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == vcpuii_pkg::S_DONE) && (!out_valid || out_ready);
  assign ptr_inc  = (fwd_ptr == LAST_IDX) ? '0 : fwd_ptr + 1'b1;
  assign chk_inc  = (chk_addr == LAST_IDX) ? '0 : chk_addr + 1'b1;
  assign eff_st   = rd_vld ? rd_q.st : vcpuii_pkg::ST_INVALID;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q   <= mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (vld_set) begin
        vld[mem_waddr] <= 1'b1;
      end
      if (vld_clr) begin
        vld[chk_addr] <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next      = state;
    fwd_ptr_next    = fwd_ptr;
    chk_addr_next   = chk_addr;
    cnt_next        = cnt;
    forwarding_next = forwarding;
    grp0_next       = grp0;
    grp1_next       = grp1;
    irq_n_next      = irq_n;
    eoir_vid_next   = eoir_vid;
    w_rdata_next    = w_rdata;
    w_eoi_v_next    = w_eoi_v;
    w_eoi_pid_next  = w_eoi_pid;
    w_err_next      = w_err;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    vld_set         = 1'b0;
    vld_clr         = 1'b0;
    mem_waddr       = chk_addr;
    mem_wdata       = rd_q;
    rd_addr         = chk_inc;

    case (state)
      vcpuii_pkg::S_IDLE: begin
        if (in_valid) begin
          w_rdata_next   = '0;
          w_eoi_v_next   = 1'b0;
          w_eoi_pid_next = '0;
          w_err_next     = 1'b0;
          state_next     = vcpuii_pkg::S_DONE;
          case (func)
            vcpuii_pkg::FUNC_TICK: begin
              if (virt_en && grp0) begin
                mem_re = 1'b1;
                if (forwarding) begin
                  rd_addr    = fwd_ptr;
                  state_next = vcpuii_pkg::S_FWD;
                end else begin
                  rd_addr    = ptr_inc;
                  cnt_next   = CW'(1);
                  state_next = vcpuii_pkg::S_SCAN;
                end
                chk_addr_next = rd_addr;
              end else begin
                forwarding_next = 1'b0;
                irq_n_next      = 1'b1;
              end
            end
            vcpuii_pkg::FUNC_READ: begin
              if (offset == vcpuii_pkg::OFF_CTLR) begin
                w_rdata_next = {30'd0, grp1, grp0};
              end else if (offset == vcpuii_pkg::OFF_IAR) begin
                if (forwarding) begin
                  mem_re        = 1'b1;
                  rd_addr       = fwd_ptr;
                  chk_addr_next = fwd_ptr;
                  state_next    = vcpuii_pkg::S_IAR;
                end else begin
                  w_rdata_next = {22'd0, vcpuii_pkg::SPURIOUS_ID};
                end
              end else begin
                w_err_next = 1'b1;
              end
            end
            vcpuii_pkg::FUNC_WRITE: begin
              if (offset == vcpuii_pkg::OFF_CTLR) begin
                grp0_next = write_data[0];
                grp1_next = write_data[1];
              end else if (offset == vcpuii_pkg::OFF_EOIR) begin
                eoir_vid_next = write_data[9:0];
                mem_re        = 1'b1;
                rd_addr       = '0;
                chk_addr_next = '0;
                cnt_next      = CW'(1);
                state_next    = vcpuii_pkg::S_EOIR;
              end else if (offset != vcpuii_pkg::OFF_PMR) begin
                w_err_next = 1'b1;
              end
            end
            default: begin
              if ({1'b0, lr_index} < 7'(NUM_LIST_REGS)) begin
                mem_we        = 1'b1;
                vld_set       = 1'b1;
                mem_waddr     = lr_index[IDXW-1:0];
                mem_wdata.st  = (lr_state_in == vcpuii_pkg::ST_RESERVED) ?
                                vcpuii_pkg::ST_INVALID : lr_state_in;
                mem_wdata.vid = lr_vid;
                mem_wdata.pid = lr_pid;
              end
            end
          endcase
        end
      end
      vcpuii_pkg::S_FWD: begin
        if (eff_st == vcpuii_pkg::ST_PENDING) begin
          irq_n_next = 1'b0;
          state_next = vcpuii_pkg::S_DONE;
        end else begin
          mem_re        = 1'b1;
          chk_addr_next = chk_inc;
          cnt_next      = CW'(1);
          state_next    = vcpuii_pkg::S_SCAN;
        end
      end
      vcpuii_pkg::S_SCAN: begin
        if (eff_st == vcpuii_pkg::ST_PENDING) begin
          fwd_ptr_next    = chk_addr;
          forwarding_next = 1'b1;
          irq_n_next      = 1'b0;
          state_next      = vcpuii_pkg::S_DONE;
        end else if (cnt == CW'(NUM_LIST_REGS)) begin
          fwd_ptr_next    = chk_addr;
          forwarding_next = 1'b0;
          irq_n_next      = 1'b1;
          state_next      = vcpuii_pkg::S_DONE;
        end else begin
          mem_re        = 1'b1;
          chk_addr_next = chk_inc;
          cnt_next      = cnt + CW'(1);
        end
      end
      vcpuii_pkg::S_IAR: begin
        if (eff_st == vcpuii_pkg::ST_PENDING) begin
          mem_we          = 1'b1;
          mem_wdata.st    = vcpuii_pkg::ST_ACTIVE;
          forwarding_next = 1'b0;
          w_rdata_next    = {22'd0, rd_q.vid};
        end else begin
          w_rdata_next = {22'd0, vcpuii_pkg::SPURIOUS_ID};
        end
        state_next = vcpuii_pkg::S_DONE;
      end
      vcpuii_pkg::S_EOIR: begin
        if (eff_st == vcpuii_pkg::ST_ACTIVE && rd_q.vid == eoir_vid) begin
          vld_clr        = 1'b1;
          w_eoi_v_next   = 1'b1;
          w_eoi_pid_next = rd_q.pid;
          state_next     = vcpuii_pkg::S_DONE;
        end else if (cnt == CW'(NUM_LIST_REGS)) begin
          w_err_next = 1'b1;
          state_next = vcpuii_pkg::S_DONE;
        end else begin
          mem_re        = 1'b1;
          chk_addr_next = chk_inc;
          cnt_next      = cnt + CW'(1);
        end
      end
      vcpuii_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = vcpuii_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = vcpuii_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= vcpuii_pkg::S_IDLE;
      fwd_ptr    <= '0;
      forwarding <= 1'b0;
      grp0       <= 1'b0;
      grp1       <= 1'b0;
      irq_n      <= 1'b1;
      virt_en    <= 1'b0;
      out_valid  <= 1'b0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      fwd_ptr    <= fwd_ptr_next;
      forwarding <= forwarding_next;
      grp0       <= grp0_next;
      grp1       <= grp1_next;
      irq_n      <= irq_n_next;
      out_valid  <= out_valid_next;
      cnt        <= cnt_next;
      if (cfg_wr_en) begin
        virt_en <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr  <= chk_addr_next;
    eoir_vid  <= eoir_vid_next;
    w_rdata   <= w_rdata_next;
    w_eoi_v   <= w_eoi_v_next;
    w_eoi_pid <= w_eoi_pid_next;
    w_err     <= w_err_next;
    if (out_load) begin
      read_data    <= w_rdata;
      virq_n       <= irq_n;
      eoi_valid    <= w_eoi_v;
      eoi_pid      <= w_eoi_pid;
      access_error <= w_err;
    end
  end

  `VCPUII_ASSERT_SAME(a_eoi_no_err, out_valid && eoi_valid, !access_error && read_data == 32'd0)
  `VCPUII_ASSERT_SAME(a_cnt_bound,
    state == vcpuii_pkg::S_SCAN || state == vcpuii_pkg::S_EOIR,
    cnt <= CW'(NUM_LIST_REGS) && cnt != '0)
  `VCPUII_ASSERT_NEXT(a_tick_off,
    in_acc && func == vcpuii_pkg::FUNC_TICK && !(virt_en && grp0),
    !forwarding && irq_n && state == vcpuii_pkg::S_DONE)
  `VCPUII_ASSERT_NEXT(a_one_result, out_load, out_valid && state == vcpuii_pkg::S_IDLE)

endmodule
